### hw/rtl/ols_pkg.sv
// Shared types and codes for the ordered list store.
// Used by ols_ctrl, ols_datapath and ordered_list_store; depends on nothing.
package ols_pkg;

   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_POP_BACK   = 3'd1,
      OP_PUSH_FRONT = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_INSERT     = 3'd4,
      OP_ERASE      = 3'd5,
      OP_FIND       = 3'd6
   } ols_op_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_FULL  = 3'd1,
      ST_EMPTY = 3'd2,
      ST_RANGE = 3'd3,
      ST_MISS  = 3'd4
   } ols_status_type;

   // What the accepted word does to the memory
   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_PUT  = 2'd1,
      KIND_TAKE = 2'd2,
      KIND_FIND = 2'd3
   } ols_kind_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_STEP = 2'd1,
      S_USE  = 2'd2,
      S_DONE = 2'd3
   } ols_state_type;

   typedef struct packed {
      logic load;
      logic read;
      logic shift;
      logic next;
      logic hit;
      logic place;
      logic commit;
   } ols_cmd_type;

   typedef struct packed {
      ols_kind_type kind;
      logic         more;
      logic         hit;
      logic         rsp_free;
   } ols_stat_type;

endpackage

### hw/rtl/ols_ctrl.sv
// Sequencer for the ordered list store: walks the shift and search sweeps.
// Depends on ols_pkg; drives commands into ols_datapath.
module ols_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ols_pkg::ols_stat_type stat,
   output ols_pkg::ols_cmd_type  cmd
);

   ols_pkg::ols_state_type state_ff;
   ols_pkg::ols_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ols_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ols_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ols_pkg::S_STEP;
            end
         end
         ols_pkg::S_STEP: begin
            if (stat.more) begin
               cmd.read = 1'b1;
               state_in = ols_pkg::S_USE;
            end else begin
               // drop the new word into the opened gap
               cmd.place = (stat.kind == ols_pkg::KIND_PUT);
               state_in  = ols_pkg::S_DONE;
            end
         end
         ols_pkg::S_USE: begin
            if (stat.kind == ols_pkg::KIND_FIND) begin
               if (stat.hit) begin
                  cmd.hit  = 1'b1;
                  state_in = ols_pkg::S_DONE;
               end else begin
                  cmd.next = 1'b1;
                  state_in = ols_pkg::S_STEP;
               end
            end else begin
               cmd.shift = 1'b1;
               state_in  = ols_pkg::S_STEP;
            end
         end
         ols_pkg::S_DONE: begin
            // hold until the output register is free
            if (stat.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ols_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ols_pkg::S_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/ols_datapath.sv
// Datapath of the ordered list store: entry memory, count, sweep cursor, result register.
// Depends on ols_pkg; commanded by ols_ctrl.
module ols_datapath #(
   parameter int DEPTH       = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [2:0]            req_op,
   input  logic signed [31:0]    req_value,
   input  logic [5:0]            req_position,
   input  ols_pkg::ols_cmd_type  cmd,
   output ols_pkg::ols_stat_type stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_status,
   output logic [5:0]            rsp_found_index,
   output logic [6:0]            rsp_entry_count
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > 6) ? CW : 6;

   logic [VALUE_WIDTH-1:0] mem [DEPTH];

   logic [CW-1:0]          count_ff, count_in;
   ols_pkg::ols_kind_type  kind_ff, kind_in;
   logic [IW-1:0]          at_ff, at_in;
   logic [CW-1:0]          cursor_ff, cursor_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   ols_pkg::ols_status_type status_ff, status_in;
   logic [5:0]             found_ff, found_in;
   logic [VALUE_WIDTH-1:0] rdata_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]             rsp_status_ff, rsp_status_in;
   logic [5:0]             rsp_found_ff, rsp_found_in;
   logic [6:0]             rsp_count_ff, rsp_count_in;

   logic                   full, empty, pos_ok;
   ols_pkg::ols_kind_type  ld_kind;
   ols_pkg::ols_status_type ld_status;
   logic [IW-1:0]          ld_at;
   logic [CW-1:0]          ld_cursor;
   logic                   more;
   logic [IW-1:0]          raddr;
   logic [CW-1:0]          cursor_up, cursor_dn;

   assign cursor_up = cursor_ff + CW'(1);
   assign cursor_dn = cursor_ff - CW'(1);

   // Decode an incoming word against the current count
   always_comb begin
      full      = (count_ff == CW'(DEPTH));
      empty     = (count_ff == '0);
      pos_ok    = (PW'(req_position) < PW'(count_ff));
      ld_kind   = ols_pkg::KIND_NONE;
      ld_status = ols_pkg::ST_OK;
      ld_at     = IW'(count_ff);
      ld_cursor = count_ff;
      unique case (req_op)
         ols_pkg::OP_PUSH_BACK: begin
            if (full) ld_status = ols_pkg::ST_FULL;
            else      ld_kind   = ols_pkg::KIND_PUT;
         end
         ols_pkg::OP_PUSH_FRONT: begin
            ld_at = '0;
            if (full) ld_status = ols_pkg::ST_FULL;
            else      ld_kind   = ols_pkg::KIND_PUT;
         end
         ols_pkg::OP_POP_BACK: begin
            ld_cursor = count_ff - CW'(1);
            if (empty) ld_status = ols_pkg::ST_EMPTY;
            else       ld_kind   = ols_pkg::KIND_TAKE;
         end
         ols_pkg::OP_POP_FRONT: begin
            ld_cursor = '0;
            if (empty) ld_status = ols_pkg::ST_EMPTY;
            else       ld_kind   = ols_pkg::KIND_TAKE;
         end
         ols_pkg::OP_INSERT: begin
            ld_at = IW'(req_position);
            if (full)         ld_status = ols_pkg::ST_FULL;
            else if (!pos_ok) ld_status = ols_pkg::ST_RANGE;
            else              ld_kind   = ols_pkg::KIND_PUT;
         end
         ols_pkg::OP_ERASE: begin
            ld_cursor = CW'(req_position);
            if (!pos_ok) ld_status = ols_pkg::ST_RANGE;
            else         ld_kind   = ols_pkg::KIND_TAKE;
         end
         ols_pkg::OP_FIND: begin
            ld_cursor = '0;
            ld_status = ols_pkg::ST_MISS;
            ld_kind   = ols_pkg::KIND_FIND;
         end
         default: begin
            ld_kind = ols_pkg::KIND_NONE;
         end
      endcase
   end

   // Sweep bounds and source address for the current step
   always_comb begin
      more  = 1'b0;
      raddr = IW'(cursor_ff);
      unique case (kind_ff)
         ols_pkg::KIND_PUT: begin
            more  = (cursor_ff > CW'(at_ff));
            raddr = IW'(cursor_dn);
         end
         ols_pkg::KIND_TAKE: begin
            more  = (cursor_up < count_ff);
            raddr = IW'(cursor_up);
         end
         ols_pkg::KIND_FIND: begin
            more  = (cursor_ff < count_ff);
         end
         default: begin
            more = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in      = count_ff;
      kind_in       = kind_ff;
      at_in         = at_ff;
      cursor_in     = cursor_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      if (cmd.load) begin
         kind_in   = ld_kind;
         status_in = ld_status;
         at_in     = ld_at;
         cursor_in = ld_cursor;
         value_in  = VALUE_WIDTH'(req_value);
         found_in  = '0;
      end
      if (cmd.shift || cmd.next) begin
         cursor_in = (kind_ff == ols_pkg::KIND_PUT) ? cursor_dn : cursor_up;
      end
      if (cmd.hit) begin
         status_in = ols_pkg::ST_OK;
         found_in  = 6'(cursor_ff);
      end
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         if (kind_ff == ols_pkg::KIND_PUT)       count_in = count_ff + CW'(1);
         else if (kind_ff == ols_pkg::KIND_TAKE) count_in = count_ff - CW'(1);
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_found_in  = found_ff;
         rsp_count_in  = 7'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         kind_ff      <= ols_pkg::KIND_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      at_ff         <= at_in;
      cursor_ff     <= cursor_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         mem[IW'(cursor_ff)] <= rdata_ff;
      end else if (cmd.place) begin
         mem[at_ff] <= value_ff;
      end
      if (cmd.read) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign stat.kind       = kind_ff;
   assign stat.more       = more;
   assign stat.hit        = (rdata_ff == value_ff);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above capacity");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> count_ff == $past(count_ff))
      else $error("count changed outside commit");

   a_hit_find: assert property (@(posedge clock) disable iff (reset)
      (cmd.hit || cmd.next) |-> kind_ff == ols_pkg::KIND_FIND)
      else $error("search step outside a find");
`endif

endmodule

### hw/rtl/ordered_list_store.sv
// Bounded ordered list of signed words with push, pop, insert, erase and find.
// Top level; depends on ols_pkg, ols_ctrl and ols_datapath.
//
// Usage: the req_ channel carries one word per operation (op, value,
// position) under valid/ready; every accepted word yields exactly one
// rsp_ word (status, found index, entry count after the operation).
// Entries live in a single-port-read, single-port-write memory, so
// insert and erase move later entries one at a time and find scans
// from index zero.
// The sequencer passes a read and a use state for every entry moved
// or compared, then commits the result from its done state. One
// operation is in flight at a time, so the next word is taken in the
// same cycle as the previous result appears at the earliest;
// req_ready is high whenever the sequencer is idle, even while the
// previous result still sits in the output register.
// A stalled receiver holds the finished result in the output register;
// the next operation then waits in its done state until that word is
// taken. Reset empties the list (count zero) and drops any pending
// result; memory contents are not cleared.
module ordered_list_store #(
   parameter int DEPTH       = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_op,
   input  logic signed [31:0] req_value,
   input  logic [5:0]         req_position,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [5:0]         rsp_found_index,
   output logic [6:0]         rsp_entry_count
);

   ols_pkg::ols_cmd_type  cmd;
   ols_pkg::ols_stat_type stat;

   ols_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ols_datapath #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_op          (req_op),
      .req_value       (req_value),
      .req_position    (req_position),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule
